// ===== hdl/trb_pkg.sv =====
// Shared types, status codes, register indices and the clock-order function of the timestamp reorder buffer.
// No dependencies.
package trb_pkg;

  localparam logic [2:0] ST_INSERTED = 3'd0;
  localparam logic [2:0] ST_POPPED   = 3'd1;
  localparam logic [2:0] ST_DRAINED  = 3'd2;
  localparam logic [2:0] ST_FULL     = 3'd3;
  localparam logic [2:0] ST_EMPTY    = 3'd4;

  localparam logic [1:0] REG_RELATIVE = 2'd0;
  localparam logic [1:0] REG_DRIFT    = 2'd1;
  localparam logic [1:0] REG_USTEP    = 2'd2;
  localparam logic [1:0] REG_KSTEP    = 2'd3;

  localparam logic [31:0] LOW32_MAX = 32'hFFFF_FFFF;

  typedef struct packed {
    logic [63:0] stamp;
    logic        source;
    logic [31:0] code;
    logic [63:0] payload;
  } entry_t;

  typedef enum logic [3:0] {
    S_IDLE  = 4'b0001,
    S_SCAN  = 4'b0010,
    S_PLACE = 4'b0100,
    S_POP   = 4'b1000
  } state_e;

  function automatic logic at_or_before(logic [31:0] x, logic [31:0] y, logic [31:0] fz);
    return (x <= y) || ((y < fz) && (x > (LOW32_MAX - fz)));
  endfunction

endpackage

// ===== hdl/trb_ram.sv =====
// Generic simple dual-port RAM: one write port, one read port with registered read data.
// No dependencies.
module trb_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);
  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;
endmodule

// ===== hdl/timestamp_reorder_buffer_core.sv =====
// Timestamp reorder buffer top level: sequencer, offset and counter logic, result register.
// Depends on trb_pkg and trb_ram.
//
// Events sit in one RAM as a ring, oldest at the head. A pop reads the head
// entry from the RAM, then loads the result register once the output is free.
// An insert into a nonempty buffer scans the stored events with a later clock:
// the scan reads one entry per cycle from the newest backward and writes it one
// slot up, so the single RAM read port sets the rate. An insert into an empty
// buffer, a drop on a full buffer or a pop on an empty one loads the result
// register in the cycle of acceptance. No clearing pass is needed after reset.
module timestamp_reorder_buffer_core #(
  parameter int DEPTH     = 64,
  parameter int FUZZ_ZONE = 16777216
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [1:0]  cfg_idx_i,
  input  logic [63:0] cfg_data_i,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic        kind_i,
  input  logic [63:0] stamp_i,
  input  logic        source_i,
  input  logic [31:0] event_code_i,
  input  logic [63:0] payload_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [2:0]  status_o,
  output logic [63:0] out_stamp_o,
  output logic        out_source_o,
  output logic [31:0] out_code_o,
  output logic [63:0] out_payload_o,
  output logic [31:0] sequence_res_o
);
  import trb_pkg::*;

  localparam int AW = $clog2(DEPTH);
  localparam int CW = $clog2(DEPTH + 1);
  localparam logic [AW:0]   DEPTH_A = (AW + 1)'(DEPTH);
  localparam logic [CW-1:0] DEPTH_C = CW'(DEPTH);
  localparam logic [31:0]   FUZZ    = 32'(FUZZ_ZONE);
  localparam int EW = $bits(entry_t);

  function automatic logic [AW-1:0] ring(logic [AW-1:0] a, logic [AW-1:0] b);
    logic [AW:0] s;
    s = {1'b0, a} + {1'b0, b};
    if (s >= DEPTH_A) begin
      s = s - DEPTH_A;
    end
    return s[AW-1:0];
  endfunction

  state_e state_q, state_d;
  logic [AW-1:0] head_q, head_d;
  logic [CW-1:0] fill_q, fill_d;
  logic [AW-1:0] k_q, k_d;
  entry_t        item_q, item_d;
  logic [63:0]   offset_q, offset_d;
  logic          latched_q, latched_d;
  logic [31:0]   count_q, count_d;
  logic          rel_q, drift_q;
  logic [63:0]   ustep_q, kstep_q;

  logic          out_valid_q, out_valid_d;
  logic [2:0]    status_q, status_d;
  logic [63:0]   ostamp_q, ostamp_d;
  logic          osource_q, osource_d;
  logic [31:0]   ocode_q, ocode_d;
  logic [63:0]   opayload_q, opayload_d;
  logic [31:0]   oseq_q, oseq_d;

  logic          we, re;
  logic [AW-1:0] waddr, raddr;
  entry_t        wdata, rdata;
  logic [EW-1:0] rdata_raw;
  logic          out_free, accept, load;
  logic [63:0]   off_eff;
  entry_t        new_item;

  trb_ram #(.WIDTH(EW), .DEPTH(DEPTH)) u_ram (
    .clk_i  (clk_i),
    .we_i   (we),
    .waddr_i(waddr),
    .wdata_i(wdata),
    .re_i   (re),
    .raddr_i(raddr),
    .rdata_o(rdata_raw)
  );
  assign rdata = entry_t'(rdata_raw);

  assign out_free   = !out_valid_q || out_ready_i;
  assign in_ready_o = (state_q == S_IDLE) && out_free;
  assign accept     = in_valid_i && in_ready_o;
  assign new_item   = '{stamp: stamp_i, source: source_i, code: event_code_i, payload: payload_i};
  assign off_eff    = (rel_q && !latched_q) ? rdata.stamp : offset_q;

  always_comb begin
    state_d    = state_q;
    head_d     = head_q;
    fill_d     = fill_q;
    k_d        = k_q;
    item_d     = item_q;
    offset_d   = offset_q;
    latched_d  = latched_q;
    count_d    = count_q;
    we         = 1'b0;
    re         = 1'b0;
    waddr      = head_q;
    raddr      = head_q;
    wdata      = item_q;
    load       = 1'b0;
    status_d   = ST_INSERTED;
    ostamp_d   = '0;
    osource_d  = 1'b0;
    ocode_d    = '0;
    opayload_d = '0;
    oseq_d     = '0;
    unique case (state_q)
      S_IDLE: begin
        if (accept) begin
          item_d = new_item;
          if (!kind_i) begin
            if (fill_q == DEPTH_C) begin
              load     = 1'b1;
              status_d = ST_FULL;
            end else if (fill_q == '0) begin
              we       = 1'b1;
              waddr    = head_q;
              wdata    = new_item;
              fill_d   = fill_q + 1'b1;
              load     = 1'b1;
              status_d = ST_INSERTED;
            end else begin
              k_d     = AW'(fill_q - 1'b1);
              re      = 1'b1;
              raddr   = ring(head_q, AW'(fill_q - 1'b1));
              state_d = S_SCAN;
            end
          end else begin
            if (fill_q == '0) begin
              load     = 1'b1;
              status_d = ST_EMPTY;
            end else begin
              re      = 1'b1;
              raddr   = head_q;
              state_d = S_POP;
            end
          end
        end
      end
      S_SCAN: begin
        if (at_or_before(rdata.stamp[31:0], item_q.stamp[31:0], FUZZ)) begin
          if (out_free) begin
            we       = 1'b1;
            waddr    = ring(head_q, k_q + 1'b1);
            wdata    = item_q;
            fill_d   = fill_q + 1'b1;
            load     = 1'b1;
            status_d = ST_INSERTED;
            state_d  = S_IDLE;
          end
        end else begin
          we    = 1'b1;
          waddr = ring(head_q, k_q + 1'b1);
          wdata = rdata;
          if (k_q == '0) begin
            state_d = S_PLACE;
          end else begin
            k_d   = k_q - 1'b1;
            re    = 1'b1;
            raddr = ring(head_q, k_q - 1'b1);
          end
        end
      end
      S_PLACE: begin
        if (out_free) begin
          we       = 1'b1;
          waddr    = head_q;
          wdata    = item_q;
          fill_d   = fill_q + 1'b1;
          load     = 1'b1;
          status_d = ST_INSERTED;
          state_d  = S_IDLE;
        end
      end
      S_POP: begin
        if (out_free) begin
          load       = 1'b1;
          status_d   = (fill_q == CW'(1)) ? ST_DRAINED : ST_POPPED;
          ostamp_d   = rdata.stamp - off_eff;
          osource_d  = rdata.source;
          ocode_d    = rdata.code;
          opayload_d = rdata.payload;
          oseq_d     = count_q;
          if (rel_q && !latched_q) begin
            latched_d = 1'b1;
          end
          offset_d = drift_q ? off_eff + (rdata.source ? kstep_q : ustep_q) : off_eff;
          count_d  = count_q + 1'b1;
          head_d   = ring(head_q, AW'(1));
          fill_d   = fill_q - 1'b1;
          state_d  = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (load) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      head_q      <= '0;
      fill_q      <= '0;
      offset_q    <= '0;
      latched_q   <= 1'b0;
      count_q     <= '0;
      rel_q       <= 1'b0;
      drift_q     <= 1'b0;
      ustep_q     <= '0;
      kstep_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      head_q      <= head_d;
      fill_q      <= fill_d;
      offset_q    <= offset_d;
      latched_q   <= latched_d;
      count_q     <= count_d;
      out_valid_q <= out_valid_d;
      if (cfg_we_i) begin
        unique case (cfg_idx_i)
          REG_RELATIVE: rel_q   <= cfg_data_i[0];
          REG_DRIFT:    drift_q <= cfg_data_i[0];
          REG_USTEP:    ustep_q <= cfg_data_i;
          REG_KSTEP:    kstep_q <= cfg_data_i;
          default: ;
        endcase
      end
    end
  end

  always_ff @(posedge clk_i) begin
    k_q    <= k_d;
    item_q <= item_d;
    if (load) begin
      status_q   <= status_d;
      ostamp_q   <= ostamp_d;
      osource_q  <= osource_d;
      ocode_q    <= ocode_d;
      opayload_q <= opayload_d;
      oseq_q     <= oseq_d;
    end
  end

  assign out_valid_o    = out_valid_q;
  assign status_o       = status_q;
  assign out_stamp_o    = ostamp_q;
  assign out_source_o   = osource_q;
  assign out_code_o     = ocode_q;
  assign out_payload_o  = opayload_q;
  assign sequence_res_o = oseq_q;

  a_fill_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fill_q <= DEPTH_C) else $error("fill count beyond depth");

  a_no_same_entry: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (we && re) |-> (waddr != raddr)) else $error("read and write hit one entry");

  a_empty_pop: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (accept && kind_i && fill_q == '0) |=> (out_valid_q && status_q == ST_EMPTY))
    else $error("pop on empty buffer not flagged");

  a_load_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    load |-> out_free) else $error("result register overwritten");
endmodule
